/* design/fru_pkg.sv */
package fru_pkg;

  localparam int IDX_W    = 16;
  localparam int IDX_FRAC = 12;
  localparam logic [IDX_W-1:0] IDX_ONE = 16'd4096;

endpackage

/* design/fresnel_reflectance_unit.sv */
// Channel  Ports                                          Direction  Handshake
// in       in_cos_incident, in_refractive_index          input      in_valid / in_stall
// out      out_reflectance                                output     out_valid / out_stall
//
// One item per cycle while the output is not stalled; the pipeline is built from the
// bit-per-stage square root, Snell divider, second square root and ratio dividers.
// Reset clears the valid bits of every stage; payload registers are not reset.
// A stalled result freezes the whole pipeline; in_stall follows out_valid and out_stall.
module fresnel_reflectance_unit import fru_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [FRAC_BITS:0]   in_cos_incident,
  input  logic [IDX_W-1:0]     in_refractive_index,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [FRAC_BITS:0]   out_reflectance
);

  localparam int F   = FRAC_BITS;
  localparam int W   = F + 1;
  localparam int SQ  = 2 * W;
  localparam int RW  = W + 4;
  localparam int T   = W + IDX_W;
  localparam int DW  = T + 2;
  localparam int NST = 3 * W + F + 6;

  localparam logic [W-1:0]  ONE_FX = {1'b1, {F{1'b0}}};
  localparam logic [SQ-1:0] ONE_SQ = SQ'(1) << (2 * F);

  typedef struct packed {
    logic [RW-1:0] rem;
    logic [W-1:0]  root;
  } sq_t;

  function automatic sq_t sq_step(input sq_t s, input logic [1:0] b);
    logic [RW-1:0] rem_sh;
    logic [RW-1:0] trial;
    sq_t           o;
    rem_sh = {s.rem[RW-3:0], b};
    trial  = RW'({s.root, 2'b01});
    if (rem_sh >= trial) begin
      o.rem  = rem_sh - trial;
      o.root = {s.root[W-2:0], 1'b1};
    end else begin
      o.rem  = rem_sh;
      o.root = {s.root[W-2:0], 1'b0};
    end
    return o;
  endfunction

  logic             en;
  logic [NST-1:0]   vld_r;

  logic [W-1:0]     sc_r [0:3*W+1];
  logic [IDX_W-1:0] sn_r [0:3*W+1];

  sq_t              a_st_r [0:W];
  logic [SQ-1:0]    a_v_r  [0:W];

  logic [W+11:0]    b_num_r [1:W];
  logic [IDX_W-1:0] b_rem_r [1:W];
  logic [W-1:0]     b_q_r   [1:W];

  sq_t              c_st_r [0:W];
  logic [SQ-1:0]    c_v_r  [0:W];

  logic [T-1:0]     d_a_r [0:1];
  logic [T-1:0]     d_b_r [0:1];

  logic [DW-1:0]    f_rem_r [0:F][0:1];
  logic [T:0]       f_den_r [0:F][0:1];
  logic             f_one_r [0:F][0:1];
  logic [F-1:0]     f_q_r   [0:F][0:1];

  logic [W-1:0]     g_r [0:1];
  logic [W-1:0]     out_r;

  logic [W-1:0]     cos_clamp;
  logic [IDX_W-1:0] idx_clamp;
  logic [SQ-1:0]    cos_sq;
  logic [SQ-1:0]    sin_at_sq;
  logic [W:0]       mean_sum;

  assign en        = !(vld_r[NST-1] && out_stall);
  assign in_stall  = !en;
  assign out_valid = vld_r[NST-1];
  assign out_reflectance = out_r;

  assign cos_clamp = (in_cos_incident > ONE_FX) ? ONE_FX : in_cos_incident;
  assign idx_clamp = (in_refractive_index < IDX_ONE) ? IDX_ONE : in_refractive_index;
  assign cos_sq    = cos_clamp * cos_clamp;
  assign sin_at_sq = b_q_r[W] * b_q_r[W];
  assign mean_sum  = {1'b0, g_r[0]} + {1'b0, g_r[1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sc_r[0]   <= cos_clamp;
      sn_r[0]   <= idx_clamp;
      a_st_r[0] <= '0;
      a_v_r[0]  <= ONE_SQ - cos_sq;
      c_st_r[0] <= '0;
      c_v_r[0]  <= ONE_SQ - sin_at_sq;
      out_r     <= mean_sum[W:1];
    end
  end

  genvar i, k, l;

  for (i = 1; i <= 3 * W + 1; i++) begin : g_side
    always_ff @(posedge clk) begin
      if (en) begin
        sc_r[i] <= sc_r[i-1];
        sn_r[i] <= sn_r[i-1];
      end
    end
  end

  for (k = 0; k < W; k++) begin : g_sqrt
    always_ff @(posedge clk) begin
      if (en) begin
        a_st_r[k+1] <= sq_step(a_st_r[k], a_v_r[k][SQ-1-2*k -: 2]);
        a_v_r[k+1]  <= a_v_r[k];
        c_st_r[k+1] <= sq_step(c_st_r[k], c_v_r[k][SQ-1-2*k -: 2]);
        c_v_r[k+1]  <= c_v_r[k];
      end
    end
  end

  for (k = 0; k < W; k++) begin : g_div
    logic [W+11:0]    num_p;
    logic [IDX_W-1:0] rem_p;
    logic [W-1:0]     q_p;
    logic [IDX_W:0]   rem_sh;
    logic [IDX_W:0]   dvs;
    logic             ge;
    if (k == 0) begin : g_head
      assign num_p = {a_st_r[W].root, 12'b0};
      assign rem_p = IDX_W'(num_p[W+11:W]);
      assign q_p   = '0;
    end else begin : g_body
      assign num_p = b_num_r[k];
      assign rem_p = b_rem_r[k];
      assign q_p   = b_q_r[k];
    end
    assign rem_sh = {rem_p, num_p[W-1-k]};
    assign dvs    = {1'b0, sn_r[W+k]};
    assign ge     = rem_sh >= dvs;
    always_ff @(posedge clk) begin
      if (en) begin
        b_num_r[k+1] <= num_p;
        b_rem_r[k+1] <= ge ? IDX_W'(rem_sh - dvs) : rem_sh[IDX_W-1:0];
        b_q_r[k+1]   <= {q_p[W-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_a_r[0] <= T'({sc_r[3*W+1], 12'b0});
      d_b_r[0] <= T'(sn_r[3*W+1] * c_st_r[W].root);
      d_a_r[1] <= T'({c_st_r[W].root, 12'b0});
      d_b_r[1] <= T'(sn_r[3*W+1] * sc_r[3*W+1]);
    end
  end

  for (l = 0; l < 2; l++) begin : g_lane
    logic [T-1:0] diff;
    logic [T:0]   den;
    logic [W-1:0] ratio;
    logic [SQ-1:0] ratio_sq;
    assign diff  = (d_a_r[l] >= d_b_r[l]) ? (d_a_r[l] - d_b_r[l]) : (d_b_r[l] - d_a_r[l]);
    assign den   = {1'b0, d_a_r[l]} + {1'b0, d_b_r[l]};
    assign ratio = f_one_r[F][l] ? ONE_FX : {1'b0, f_q_r[F][l]};
    assign ratio_sq = ratio * ratio;
    always_ff @(posedge clk) begin
      if (en) begin
        f_rem_r[0][l] <= DW'(diff);
        f_den_r[0][l] <= den;
        f_one_r[0][l] <= (den == '0) || ({1'b0, diff} >= den);
        f_q_r[0][l]   <= '0;
        g_r[l]        <= ratio_sq[F+W-1:F];
      end
    end
    for (k = 0; k < F; k++) begin : g_ratio
      logic [DW-1:0] rem_sh;
      logic          ge;
      assign rem_sh = {f_rem_r[k][l][DW-2:0], 1'b0};
      assign ge     = rem_sh >= DW'(f_den_r[k][l]);
      always_ff @(posedge clk) begin
        if (en) begin
          f_rem_r[k+1][l] <= ge ? (rem_sh - DW'(f_den_r[k][l])) : rem_sh;
          f_den_r[k+1][l] <= f_den_r[k][l];
          f_one_r[k+1][l] <= f_one_r[k][l];
          f_q_r[k+1][l]   <= {f_q_r[k][l][F-2:0], ge};
        end
      end
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> out_reflectance <= ONE_FX)
    else $error("reflectance above one");
  assert property (@(posedge clk) disable iff (!rst_n) in_stall |=> $stable(vld_r))
    else $error("pipeline advanced during stall");
  assert property (@(posedge clk) disable iff (!rst_n) !in_stall |=> vld_r[0] == $past(in_valid))
    else $error("transfer lost at pipeline entry");
  assert property (@(posedge clk) disable iff (!rst_n) vld_r[2*W] |-> b_q_r[W] <= ONE_FX)
    else $error("transmitted sine above one");

endmodule

/* tb/tb_fresnel_reflectance_unit.sv */
`timescale 1ns / 100ps

module tb_fresnel_reflectance_unit;
  import fru_pkg::*;

  localparam int FB = 16;
  localparam longint ONE = 64'd1 << FB;
  localparam int LAT = 3 * (FB + 1) + FB + 6;
  localparam int N_RANDOM = 1030;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [FB:0] in_cos_incident = '0;
  logic [IDX_W-1:0] in_refractive_index = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [FB:0] out_reflectance;

  fresnel_reflectance_unit #(.FRAC_BITS(FB)) dut (.*);

  always #5 clk = ~clk;

  typedef struct {
    logic [FB:0] cos_i;
    logic [IDX_W-1:0] idx;
    logic has_known;
    logic [FB:0] known;
  } stim_row_t;

  localparam int N_DIRECTED = 16;
  stim_row_t directed_rows [N_DIRECTED] = '{
    '{17'd0, IDX_ONE, 1'b1, 17'd65536},
    '{17'd65536, IDX_ONE, 1'b1, 17'd0},
    '{17'd131071, IDX_ONE, 1'b1, 17'd0},
    '{17'd0, 16'd0, 1'b1, 17'd65536},
    '{17'd65536, 16'd4095, 1'b1, 17'd0},
    '{17'd0, 16'd65535, 1'b0, 17'd0},
    '{17'd65536, 16'd65535, 1'b0, 17'd0},
    '{17'd131071, 16'd65535, 1'b0, 17'd0},
    '{17'd65537, 16'd6144, 1'b0, 17'd0},
    '{17'd1, IDX_ONE, 1'b0, 17'd0},
    '{17'd1, 16'd65535, 1'b0, 17'd0},
    '{17'd46341, 16'd6144, 1'b0, 17'd0},
    '{17'd32768, 16'd5461, 1'b0, 17'd0},
    '{17'd65535, 16'd4097, 1'b0, 17'd0},
    '{17'd21845, 16'd43690, 1'b0, 17'd0},
    '{17'd0, 16'd4097, 1'b0, 17'd0}
  };

  logic [FB:0] pending_reflectance [$];
  int n_errors = 0;
  int n_results = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  longint cycle_count = 0;

  function automatic longint isqrt_floor(longint v);
    longint root;
    longint b;
    root = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= root + b) begin
        v = v - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  function automatic longint squared_ratio(longint a, longint b);
    longint diff;
    longint den;
    longint r;
    diff = (a >= b) ? a - b : b - a;
    den = a + b;
    if (den == 0 || diff >= den) r = ONE;
    else r = (diff << FB) / den;
    return (r * r) >> FB;
  endfunction

  function automatic logic [FB:0] fresnel_mean(logic [FB:0] cos_i, logic [IDX_W-1:0] idx);
    longint c;
    longint n;
    longint sin_ai;
    longint sin_at;
    longint cos_at;
    longint rs;
    longint rp;
    c = cos_i;
    n = idx;
    if (c > ONE) c = ONE;
    if (n < IDX_ONE) n = IDX_ONE;
    sin_ai = isqrt_floor(ONE * ONE - c * c);
    sin_at = (sin_ai << IDX_FRAC) / n;
    if (sin_at > ONE) sin_at = ONE;
    cos_at = isqrt_floor(ONE * ONE - sin_at * sin_at);
    rs = squared_ratio(c << IDX_FRAC, n * cos_at);
    rp = squared_ratio(cos_at << IDX_FRAC, n * c);
    return (FB+1)'((rs + rp) >> 1);
  endfunction

  task automatic send_item(logic [FB:0] cos_i, logic [IDX_W-1:0] idx);
    while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cos_incident <= cos_i;
    in_refractive_index <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_reflectance.push_back(fresnel_mean(cos_i, idx));
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
    if (rst_n && out_valid && !out_stall) begin
      n_results <= n_results + 1;
      if (pending_reflectance.size() == 0) begin
        $error("unexpected transfer: reflectance actual %0d", out_reflectance);
        n_errors <= n_errors + 1;
      end else begin
        if (out_reflectance !== pending_reflectance[0]) begin
          $error("reflectance expected %0d actual %0d", pending_reflectance[0],
                 out_reflectance);
          n_errors <= n_errors + 1;
        end
        void'(pending_reflectance.pop_front());
      end
    end
    out_stall <= (stall_pct > 0) && ($urandom_range(99, 0) < stall_pct);
  end

  task automatic random_item();
    logic [FB:0] c;
    logic [IDX_W-1:0] n;
    int sel;
    sel = $urandom_range(9, 0);
    case (sel)
      0: c = (FB+1)'($urandom_range(131071, 0));
      1: c = (FB+1)'($urandom_range(65536, 60000));
      2: c = (FB+1)'($urandom_range(2000, 0));
      default: c = (FB+1)'($urandom_range(65536, 0));
    endcase
    sel = $urandom_range(9, 0);
    case (sel)
      0: n = IDX_W'($urandom_range(4095, 0));
      1: n = IDX_W'($urandom_range(4200, 4096));
      2: n = IDX_W'($urandom_range(65535, 32768));
      default: n = IDX_W'($urandom_range(12288, 4096));
    endcase
    send_item(c, n);
  endtask

  initial begin
    int settle;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].cos_i, directed_rows[i].idx);
      if (directed_rows[i].has_known &&
          pending_reflectance[$] !== directed_rows[i].known) begin
        $error("reflectance expected %0d actual %0d", directed_rows[i].known,
               pending_reflectance[$]);
        n_errors++;
      end
    end

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0; stall_pct = 0; end
        1: begin send_idle_pct = 76; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 76; end
        3: begin send_idle_pct = 29; stall_pct = 29; end
        default: begin send_idle_pct = 0; stall_pct = 0; end
      endcase
      for (int k = 0; k < N_RANDOM / 5; k++) random_item();
    end
    in_valid <= 1'b0;
    stall_pct = 0;

    while (pending_reflectance.size() != 0) @(posedge clk);
    settle = 0;
    while (settle < LAT + 20) begin
      @(posedge clk);
      settle++;
    end

    $display("checked %0d reflectance results: clamped cosines, sub-unity indices,",
             n_results);
    $display("the zero-over-zero case and random angles under four handshake mixes");
    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
